// ===== hw/rtl/scaled_sphere_collision_test_unit_assert.svh =====
// assertion macros for the sphere collision test unit
`ifndef SCALED_SPHERE_COLLISION_TEST_UNIT_ASSERT_SVH
`define SCALED_SPHERE_COLLISION_TEST_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SSCU_ASSERT_IMP(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("sscu: implication check failed");

// next-cycle implication, checked outside reset
`define SSCU_ASSERT_NXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("sscu: next-cycle check failed");

`endif

// ===== hw/rtl/sscu_pkg.sv =====
// shared constants, types and helpers for the sphere collision test unit
`default_nettype none

package sscu_pkg;

    localparam int COMP_BITS      = 16;
    localparam int NUM_AXES       = 3;
    localparam int VEC_BITS       = 48;
    localparam int RAD_FIELD_BITS = 16;
    localparam int FRAC_SHIFT     = 8;
    localparam int NUM_STAGES     = 5;

    localparam int VEC_EXT_BITS = (NUM_AXES * COMP_BITS > VEC_BITS) ?
                                  NUM_AXES * COMP_BITS : VEC_BITS;
    localparam int PROD_BITS    = 2 * COMP_BITS;
    localparam int WORLD_BITS   = 2 * COMP_BITS + 1;
    localparam int DIFF_BITS    = WORLD_BITS + 1;
    localparam int MAG_BITS     = 2 * COMP_BITS + 1;
    localparam int SQ_BITS      = 2 * MAG_BITS;
    localparam int DIST_BITS    = SQ_BITS + 2;
    localparam int RADW_BITS    = 2 * COMP_BITS;
    localparam int RSUM_BITS    = RADW_BITS + 1;
    localparam int LIM_BITS     = 2 * RSUM_BITS;

    typedef enum logic
    {
        OP_SPHERE = 1'b0,
        OP_BOX    = 1'b1
    } opcode_t;

    typedef logic signed [COMP_BITS-1:0]  comp_t;
    typedef logic        [COMP_BITS-1:0]  ucomp_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [WORLD_BITS-1:0] world_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic        [MAG_BITS-1:0]   mag_t;
    typedef logic        [SQ_BITS-1:0]    sq_t;
    typedef logic        [DIST_BITS-1:0]  dist_t;
    typedef logic        [RADW_BITS-1:0]  radw_t;
    typedef logic        [RSUM_BITS-1:0]  rsum_t;
    typedef logic        [LIM_BITS-1:0]   lim_t;

    // load enables, one per pipeline register stage
    typedef struct packed
    {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_en_t;

    // component of a packed vector; bits past the field read as zero
    function automatic comp_t get_comp(input logic [VEC_BITS-1:0] vec, input int axis);
        logic [VEC_EXT_BITS-1:0] ext;
        ext = VEC_EXT_BITS'(vec);
        return $signed(ext[axis*COMP_BITS +: COMP_BITS]);
    endfunction

    function automatic ucomp_t comp_mag(input comp_t v);
        comp_t neg;
        neg = -v;
        return v[COMP_BITS-1] ? $unsigned(neg) : $unsigned(v);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sscu_world.sv =====
// stages 1-2: scale products, largest scale, world coordinates and radii
`default_nettype none

module sscu_world
(
    input  wire logic                             clk,
    input  wire sscu_pkg::pipe_en_t               en,
    input  wire logic                             opcode,
    input  wire logic                             tested,
    input  wire logic [sscu_pkg::VEC_BITS-1:0]    sphere_center,
    input  wire logic [sscu_pkg::RAD_FIELD_BITS-1:0] sphere_radius,
    input  wire logic [sscu_pkg::VEC_BITS-1:0]    sphere_scale,
    input  wire logic [sscu_pkg::VEC_BITS-1:0]    sphere_position,
    input  wire logic [sscu_pkg::VEC_BITS-1:0]    other_center_or_min,
    input  wire logic [sscu_pkg::RAD_FIELD_BITS-1:0] other_radius,
    input  wire logic [sscu_pkg::VEC_BITS-1:0]    other_max,
    input  wire logic [sscu_pkg::VEC_BITS-1:0]    other_scale,
    input  wire logic [sscu_pkg::VEC_BITS-1:0]    other_position,
    output sscu_pkg::opcode_t                     op_out,
    output logic                                  tested_out,
    output sscu_pkg::world_t                      wc_out [sscu_pkg::NUM_AXES],
    output sscu_pkg::world_t                      wa_out [sscu_pkg::NUM_AXES],
    output sscu_pkg::world_t                      wb_out [sscu_pkg::NUM_AXES],
    output sscu_pkg::radw_t                       ra_out,
    output sscu_pkg::radw_t                       rb_out
);

    // stage 1 registers
    sscu_pkg::prod_t   prod_c_reg [sscu_pkg::NUM_AXES];
    sscu_pkg::prod_t   prod_a_reg [sscu_pkg::NUM_AXES];
    sscu_pkg::prod_t   prod_b_reg [sscu_pkg::NUM_AXES];
    sscu_pkg::comp_t   pos_s_reg  [sscu_pkg::NUM_AXES];
    sscu_pkg::comp_t   pos_o_reg  [sscu_pkg::NUM_AXES];
    sscu_pkg::ucomp_t  rad_s_reg;
    sscu_pkg::ucomp_t  rad_o_reg;
    sscu_pkg::ucomp_t  max_s_reg;
    sscu_pkg::ucomp_t  max_o_reg;
    sscu_pkg::opcode_t op1_reg;
    logic              tested1_reg;

    // stage 2 registers
    sscu_pkg::world_t  wc_reg [sscu_pkg::NUM_AXES];
    sscu_pkg::world_t  wa_reg [sscu_pkg::NUM_AXES];
    sscu_pkg::world_t  wb_reg [sscu_pkg::NUM_AXES];
    sscu_pkg::radw_t   ra_reg;
    sscu_pkg::radw_t   rb_reg;
    sscu_pkg::opcode_t op2_reg;
    logic              tested2_reg;

    sscu_pkg::ucomp_t  max_s_next;
    sscu_pkg::ucomp_t  max_o_next;

    function automatic sscu_pkg::ucomp_t max_abs(input logic [sscu_pkg::VEC_BITS-1:0] s);
        sscu_pkg::ucomp_t best;
        sscu_pkg::ucomp_t m;
        best = '0;
        for (int i = 0; i < sscu_pkg::NUM_AXES; i++)
        begin
            m = sscu_pkg::comp_mag(sscu_pkg::get_comp(s, i));
            if (m > best)
            begin
                best = m;
            end
        end
        return best;
    endfunction

    always_comb
    begin
        max_s_next = max_abs(sphere_scale);
        max_o_next = max_abs(other_scale);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            for (int i = 0; i < sscu_pkg::NUM_AXES; i++)
            begin
                prod_c_reg[i] <= sscu_pkg::get_comp(sphere_center, i)
                               * sscu_pkg::get_comp(sphere_scale, i);
                prod_a_reg[i] <= sscu_pkg::get_comp(other_center_or_min, i)
                               * sscu_pkg::get_comp(other_scale, i);
                prod_b_reg[i] <= sscu_pkg::get_comp(other_max, i)
                               * sscu_pkg::get_comp(other_scale, i);
                pos_s_reg[i]  <= sscu_pkg::get_comp(sphere_position, i);
                pos_o_reg[i]  <= sscu_pkg::get_comp(other_position, i);
            end
            rad_s_reg   <= sscu_pkg::COMP_BITS'(sphere_radius);
            rad_o_reg   <= sscu_pkg::COMP_BITS'(other_radius);
            max_s_reg   <= max_s_next;
            max_o_reg   <= max_o_next;
            op1_reg     <= sscu_pkg::opcode_t'(opcode);
            tested1_reg <= tested;
        end
    end

    // positions move to the product's scale by the fraction width
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            for (int i = 0; i < sscu_pkg::NUM_AXES; i++)
            begin
                wc_reg[i] <= sscu_pkg::WORLD_BITS'(prod_c_reg[i])
                           + (sscu_pkg::WORLD_BITS'(pos_s_reg[i]) <<< sscu_pkg::FRAC_SHIFT);
                wa_reg[i] <= sscu_pkg::WORLD_BITS'(prod_a_reg[i])
                           + (sscu_pkg::WORLD_BITS'(pos_o_reg[i]) <<< sscu_pkg::FRAC_SHIFT);
                wb_reg[i] <= sscu_pkg::WORLD_BITS'(prod_b_reg[i])
                           + (sscu_pkg::WORLD_BITS'(pos_o_reg[i]) <<< sscu_pkg::FRAC_SHIFT);
            end
            ra_reg      <= sscu_pkg::RADW_BITS'(rad_s_reg) * sscu_pkg::RADW_BITS'(max_s_reg);
            rb_reg      <= sscu_pkg::RADW_BITS'(rad_o_reg) * sscu_pkg::RADW_BITS'(max_o_reg);
            op2_reg     <= op1_reg;
            tested2_reg <= tested1_reg;
        end
    end

    assign op_out     = op2_reg;
    assign tested_out = tested2_reg;
    assign wc_out     = wc_reg;
    assign wa_out     = wa_reg;
    assign wb_out     = wb_reg;
    assign ra_out     = ra_reg;
    assign rb_out     = rb_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sscu_clamp.sv =====
// stage 3: box clamp or centre difference per axis, and the radius limit
`default_nettype none

module sscu_clamp
(
    input  wire logic                clk,
    input  wire sscu_pkg::pipe_en_t  en,
    input  wire sscu_pkg::opcode_t   op,
    input  wire logic                tested,
    input  wire sscu_pkg::world_t    wc [sscu_pkg::NUM_AXES],
    input  wire sscu_pkg::world_t    wa [sscu_pkg::NUM_AXES],
    input  wire sscu_pkg::world_t    wb [sscu_pkg::NUM_AXES],
    input  wire sscu_pkg::radw_t     ra,
    input  wire sscu_pkg::radw_t     rb,
    output logic                     tested_out,
    output sscu_pkg::mag_t           mag_out [sscu_pkg::NUM_AXES],
    output sscu_pkg::rsum_t          rsum_out
);

    sscu_pkg::mag_t  mag_reg [sscu_pkg::NUM_AXES];
    sscu_pkg::rsum_t rsum_reg;
    logic            tested3_reg;

    sscu_pkg::world_t lo   [sscu_pkg::NUM_AXES];
    sscu_pkg::world_t hi   [sscu_pkg::NUM_AXES];
    sscu_pkg::world_t clmp [sscu_pkg::NUM_AXES];
    sscu_pkg::diff_t  d    [sscu_pkg::NUM_AXES];
    sscu_pkg::diff_t  dneg [sscu_pkg::NUM_AXES];
    sscu_pkg::mag_t   mag_next [sscu_pkg::NUM_AXES];
    sscu_pkg::rsum_t  rsum_next;

    always_comb
    begin
        for (int i = 0; i < sscu_pkg::NUM_AXES; i++)
        begin
            // corners ordered per axis, so a swapped box still spans its extent
            lo[i] = (wa[i] < wb[i]) ? wa[i] : wb[i];
            hi[i] = (wa[i] < wb[i]) ? wb[i] : wa[i];
            if (wc[i] < lo[i])
            begin
                clmp[i] = lo[i];
            end
            else if (wc[i] > hi[i])
            begin
                clmp[i] = hi[i];
            end
            else
            begin
                clmp[i] = wc[i];
            end
            if (op == sscu_pkg::OP_BOX)
            begin
                d[i] = sscu_pkg::DIFF_BITS'(wc[i]) - sscu_pkg::DIFF_BITS'(clmp[i]);
            end
            else
            begin
                d[i] = sscu_pkg::DIFF_BITS'(wa[i]) - sscu_pkg::DIFF_BITS'(wc[i]);
            end
            dneg[i]     = -d[i];
            mag_next[i] = d[i][sscu_pkg::DIFF_BITS-1] ? sscu_pkg::MAG_BITS'(dneg[i])
                                                      : sscu_pkg::MAG_BITS'(d[i]);
        end
        if (op == sscu_pkg::OP_BOX)
        begin
            rsum_next = sscu_pkg::RSUM_BITS'(ra);
        end
        else
        begin
            rsum_next = sscu_pkg::RSUM_BITS'(ra) + sscu_pkg::RSUM_BITS'(rb);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            mag_reg     <= mag_next;
            rsum_reg    <= rsum_next;
            tested3_reg <= tested;
        end
    end

    assign tested_out = tested3_reg;
    assign mag_out    = mag_reg;
    assign rsum_out   = rsum_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sscu_cmp.sv =====
// stages 4-5: squares, squared distance sum and the final compare
`default_nettype none

module sscu_cmp
(
    input  wire logic                clk,
    input  wire sscu_pkg::pipe_en_t  en,
    input  wire logic                tested,
    input  wire sscu_pkg::mag_t      mag [sscu_pkg::NUM_AXES],
    input  wire sscu_pkg::rsum_t     rsum,
    output logic                     hit
);

    sscu_pkg::sq_t  sq_reg [sscu_pkg::NUM_AXES];
    sscu_pkg::lim_t lim_reg;
    logic           tested4_reg;
    logic           hit_reg;

    sscu_pkg::dist_t dist_sum;
    logic            hit_next;

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            for (int i = 0; i < sscu_pkg::NUM_AXES; i++)
            begin
                sq_reg[i] <= sscu_pkg::SQ_BITS'(mag[i]) * sscu_pkg::SQ_BITS'(mag[i]);
            end
            lim_reg     <= sscu_pkg::LIM_BITS'(rsum) * sscu_pkg::LIM_BITS'(rsum);
            tested4_reg <= tested;
        end
    end

    always_comb
    begin
        dist_sum = '0;
        for (int i = 0; i < sscu_pkg::NUM_AXES; i++)
        begin
            dist_sum = dist_sum + sscu_pkg::DIST_BITS'(sq_reg[i]);
        end
        // touching counts as a hit; an invalid shape never hits
        hit_next = tested4_reg && (dist_sum <= sscu_pkg::DIST_BITS'(lim_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/scaled_sphere_collision_test_unit.sv =====
// top level of the sphere-sphere / sphere-box collision test pipeline
// pipeline: one register per stage from input transfer to result valid
// throughput: one test per cycle; a stalled output holds the last stage, stages behind a gap
// keep moving until all five are full, then the input is refused
// reset: asynchronous active low, clears the stage valid bits only, no clearing pass
`default_nettype none

`include "scaled_sphere_collision_test_unit_assert.svh"

module scaled_sphere_collision_test_unit
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                opcode,
    input  wire logic                                sphere_valid,
    input  wire logic [sscu_pkg::VEC_BITS-1:0]       sphere_center,
    input  wire logic [sscu_pkg::RAD_FIELD_BITS-1:0] sphere_radius,
    input  wire logic [sscu_pkg::VEC_BITS-1:0]       sphere_scale,
    input  wire logic [sscu_pkg::VEC_BITS-1:0]       sphere_position,
    input  wire logic                                other_valid,
    input  wire logic [sscu_pkg::VEC_BITS-1:0]       other_center_or_min,
    input  wire logic [sscu_pkg::RAD_FIELD_BITS-1:0] other_radius,
    input  wire logic [sscu_pkg::VEC_BITS-1:0]       other_max,
    input  wire logic [sscu_pkg::VEC_BITS-1:0]       other_scale,
    input  wire logic [sscu_pkg::VEC_BITS-1:0]       other_position,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     hit
);

    logic [sscu_pkg::NUM_STAGES-1:0] stage_valid_reg;
    logic [sscu_pkg::NUM_STAGES-1:0] stage_valid_next;
    logic [sscu_pkg::NUM_STAGES-1:0] stage_en;
    sscu_pkg::pipe_en_t              pipe_en;

    sscu_pkg::opcode_t op2;
    logic              tested2;
    logic              tested3;
    sscu_pkg::world_t  wc [sscu_pkg::NUM_AXES];
    sscu_pkg::world_t  wa [sscu_pkg::NUM_AXES];
    sscu_pkg::world_t  wb [sscu_pkg::NUM_AXES];
    sscu_pkg::radw_t   ra;
    sscu_pkg::radw_t   rb;
    sscu_pkg::mag_t    mag [sscu_pkg::NUM_AXES];
    sscu_pkg::rsum_t   rsum;

    // a stage loads when it is empty or its contents move on this cycle
    always_comb
    begin
        stage_en[sscu_pkg::NUM_STAGES-1] = !stage_valid_reg[sscu_pkg::NUM_STAGES-1]
                                           || out_ready;
        for (int s = sscu_pkg::NUM_STAGES - 2; s >= 0; s--)
        begin
            stage_en[s] = !stage_valid_reg[s] || stage_en[s+1];
        end
        stage_valid_next[0] = stage_en[0] ? in_valid : stage_valid_reg[0];
        for (int s = 1; s < sscu_pkg::NUM_STAGES; s++)
        begin
            stage_valid_next[s] = stage_en[s] ? stage_valid_reg[s-1] : stage_valid_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    assign pipe_en.s1 = stage_en[0];
    assign pipe_en.s2 = stage_en[1];
    assign pipe_en.s3 = stage_en[2];
    assign pipe_en.s4 = stage_en[3];
    assign pipe_en.s5 = stage_en[4];

    assign in_ready  = stage_en[0];
    assign out_valid = stage_valid_reg[sscu_pkg::NUM_STAGES-1];

    sscu_world u_world
    (
        .clk                 (clk),
        .en                  (pipe_en),
        .opcode              (opcode),
        .tested              (sphere_valid & other_valid),
        .sphere_center       (sphere_center),
        .sphere_radius       (sphere_radius),
        .sphere_scale        (sphere_scale),
        .sphere_position     (sphere_position),
        .other_center_or_min (other_center_or_min),
        .other_radius        (other_radius),
        .other_max           (other_max),
        .other_scale         (other_scale),
        .other_position      (other_position),
        .op_out              (op2),
        .tested_out          (tested2),
        .wc_out              (wc),
        .wa_out              (wa),
        .wb_out              (wb),
        .ra_out              (ra),
        .rb_out              (rb)
    );

    sscu_clamp u_clamp
    (
        .clk        (clk),
        .en         (pipe_en),
        .op         (op2),
        .tested     (tested2),
        .wc         (wc),
        .wa         (wa),
        .wb         (wb),
        .ra         (ra),
        .rb         (rb),
        .tested_out (tested3),
        .mag_out    (mag),
        .rsum_out   (rsum)
    );

    sscu_cmp u_cmp
    (
        .clk    (clk),
        .en     (pipe_en),
        .tested (tested3),
        .mag    (mag),
        .rsum   (rsum),
        .hit    (hit)
    );

    // a free output means the whole pipe can move
    `SSCU_ASSERT_IMP(a_ready_when_drained, out_ready, in_ready)
    // input is refused only when every stage is occupied
    `SSCU_ASSERT_IMP(a_stall_only_when_full, !in_ready, &stage_valid_reg)
    // items in flight change only by transfers at either end
    `SSCU_ASSERT_IMP(a_occupancy, $past(rst_n), $countones(stage_valid_reg) == $countones($past(stage_valid_reg)) + int'($past(in_valid && in_ready)) - int'($past(out_valid && out_ready)))

endmodule

`default_nettype wire
